>>> hw/rtl/bfm_pkg.sv
package bfm_pkg;

  localparam int MAX_WIDTH_DEF = 256;
  localparam int MAX_HEIGHT    = 4096;

  localparam int PIX_BITS      = 8;
  localparam int FRAME_W_BITS  = 9;
  localparam int FRAME_H_BITS  = 13;
  localparam int ROW_BITS      = 12;
  localparam int CSUM_BITS     = 10;
  localparam int WSUM_BITS     = 12;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = FRAME_H_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [FRAME_W_BITS-1:0] FRAME_W_RESET = FRAME_W_BITS'(10);
  localparam logic [FRAME_H_BITS-1:0] FRAME_H_RESET = FRAME_H_BITS'(10);

  // divide by nine as multiply by 3641 / 2^15, exact for sums below 2^15
  localparam int RECIP_BITS  = 12;
  localparam logic [RECIP_BITS-1:0] RECIP_NINE = RECIP_BITS'(3641);
  localparam int RECIP_SHIFT = 15;

  typedef struct packed {
    logic emit;
    logic frame_end;
  } pos_flags_t;

endpackage

>>> hw/rtl/bfm_line_ram.sv
module bfm_line_ram #(
  parameter int Depth    = bfm_pkg::MAX_WIDTH_DEF,
  parameter int DataBits = 2 * bfm_pkg::PIX_BITS,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [AddrBits-1:0] rd_addr_i,
  output logic [DataBits-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AddrBits-1:0] wr_addr_i,
  input  logic [DataBits-1:0] wr_data_i
);

  logic [DataBits-1:0] mem [Depth];
  logic [DataBits-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/bfm_scan_ctrl.sv
module bfm_scan_ctrl #(
  parameter int MaxWidth = bfm_pkg::MAX_WIDTH_DEF,
  localparam int ColBits = $clog2(MaxWidth)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bfm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [bfm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               step_i,
  output logic [ColBits-1:0]                 col_o,
  output bfm_pkg::pos_flags_t                flags_o
);

  localparam int WBits   = $clog2(MaxWidth + 1);
  localparam int CmpBits = (WBits > bfm_pkg::FRAME_W_BITS) ? WBits : bfm_pkg::FRAME_W_BITS;
  localparam int HBits   = bfm_pkg::FRAME_H_BITS;
  localparam int RowBits = bfm_pkg::ROW_BITS;

  logic [bfm_pkg::FRAME_W_BITS-1:0] width_q;
  logic [HBits-1:0]                 height_q;
  logic [ColBits-1:0]               col_q, col_d;
  logic [RowBits-1:0]               row_q, row_d;

  logic [CmpBits-1:0] wide_w, w_lim, w_last;
  logic [HBits-1:0]   h_lim, h_last;
  logic               row_end, frame_end;

  always_comb begin
    wide_w = CmpBits'(width_q);
    if (wide_w < CmpBits'(3)) begin
      w_lim = CmpBits'(3);
    end else if (wide_w > CmpBits'(MaxWidth)) begin
      w_lim = CmpBits'(MaxWidth);
    end else begin
      w_lim = wide_w;
    end
    w_last = w_lim - CmpBits'(1);

    if (height_q < HBits'(3)) begin
      h_lim = HBits'(3);
    end else if (height_q > HBits'(bfm_pkg::MAX_HEIGHT)) begin
      h_lim = HBits'(bfm_pkg::MAX_HEIGHT);
    end else begin
      h_lim = height_q;
    end
    h_last = h_lim - HBits'(1);

    row_end   = CmpBits'(col_q) >= w_last;
    frame_end = row_end && (HBits'(row_q) >= h_last);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + RowBits'(1);
      end else begin
        col_d = col_q + ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bfm_pkg::FRAME_W_RESET;
      height_q <= bfm_pkg::FRAME_H_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfm_pkg::REG_FRAME_WIDTH: begin
          width_q <= cfg_data_i[bfm_pkg::FRAME_W_BITS-1:0];
        end
        bfm_pkg::REG_FRAME_HEIGHT: begin
          height_q <= cfg_data_i[HBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign col_o             = col_q;
  assign flags_o.emit      = (row_q >= RowBits'(2)) && (col_q >= ColBits'(2));
  assign flags_o.frame_end = frame_end;

endmodule

>>> hw/rtl/box_filter_3x3_mean.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------
// in       | input     | in_valid_i / in_stall_o | pixel_value_i
// out      | output    | out_valid_o/out_stall_i | window_mean_o, frame_done_o
// cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// one pixel per cycle sustained while out_stall_i is low; a result reaches the
// output register after its pixel beat passes the line memory read, the sum
// stage and the reciprocal multiply stage
// rst_ni clears counters, column sums and valids; configuration resets to 10 x 10
// the line memory is not cleared, the first two rows of a frame only fill it
// an output stall backs up through the sum and multiply stages into in_stall_o
module box_filter_3x3_mean #(
  parameter int MaxWidth = bfm_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bfm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [bfm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bfm_pkg::PIX_BITS-1:0]       pixel_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bfm_pkg::PIX_BITS-1:0]       window_mean_o,
  output logic                               frame_done_o
);

  localparam int ColBits  = $clog2(MaxWidth);
  localparam int PixBits  = bfm_pkg::PIX_BITS;
  localparam int CsBits   = bfm_pkg::CSUM_BITS;
  localparam int WsBits   = bfm_pkg::WSUM_BITS;
  localparam int ProdBits = WsBits + bfm_pkg::RECIP_BITS;
  localparam int Shift    = bfm_pkg::RECIP_SHIFT;

  logic                in_accept;
  logic [ColBits-1:0]  scan_col;
  bfm_pkg::pos_flags_t scan_flags;

  logic                s1_valid_q;
  logic [PixBits-1:0]  s1_px_q;
  logic [ColBits-1:0]  s1_col_q;
  bfm_pkg::pos_flags_t s1_flags_q;
  logic                s1_fire;

  logic [2*PixBits-1:0] rd_data;
  logic [PixBits-1:0]   rd_upper, rd_middle;
  logic [CsBits-1:0]    cur_sum;
  logic [CsBits-1:0]    csum_prev_q, csum_prev2_q;
  logic [WsBits-1:0]    win_sum;

  logic               s2_valid_q;
  logic [WsBits-1:0]  s2_sum_q;
  logic               s2_last_q;
  logic               s2_ready;

  logic               out_valid_q;
  logic [PixBits-1:0] out_mean_q;
  logic               out_last_q;
  logic               out_ready;
  logic [ProdBits-1:0] product;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_fire    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  bfm_scan_ctrl #(
    .MaxWidth (MaxWidth)
  ) u_scan_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_accept),
    .col_o      (scan_col),
    .flags_o    (scan_flags)
  );

  // entry holds {row two above, row one above}
  bfm_line_ram #(
    .Depth    (MaxWidth),
    .DataBits (2 * PixBits)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (scan_col),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_fire),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({rd_middle, s1_px_q})
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q    <= pixel_value_i;
      s1_col_q   <= scan_col;
      s1_flags_q <= scan_flags;
    end
  end

  assign rd_upper  = rd_data[2*PixBits-1:PixBits];
  assign rd_middle = rd_data[PixBits-1:0];
  assign cur_sum   = CsBits'(rd_upper) + CsBits'(rd_middle) + CsBits'(s1_px_q);
  assign win_sum   = WsBits'(csum_prev2_q) + WsBits'(csum_prev_q) + WsBits'(cur_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_prev_q  <= '0;
      csum_prev2_q <= '0;
    end else if (s1_fire) begin
      csum_prev_q  <= cur_sum;
      csum_prev2_q <= csum_prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_fire && s1_flags_q.emit) begin
      s2_valid_q <= 1'b1;
    end else if (out_ready) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_flags_q.emit) begin
      s2_sum_q  <= win_sum;
      s2_last_q <= s1_flags_q.frame_end;
    end
  end

  assign product = ProdBits'(s2_sum_q) * ProdBits'(bfm_pkg::RECIP_NINE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_valid_q && out_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && out_ready) begin
      out_mean_q <= product[Shift+PixBits-1:Shift];
      out_last_q <= s2_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_mean_o = out_mean_q;
  assign frame_done_o  = out_last_q;

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty sum stage");

  a_no_addr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && in_accept) |-> (s1_col_q != scan_col))
    else $error("line memory read and write hit the same column");

  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("pixel accepted with full pipeline");

  a_result_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("sum stage result did not reach output register");

endmodule
